// ----- rtl/srp_pkg.sv -----
`default_nettype none

package srp_pkg;

  // Store depth default and the largest number of results one run can give.
  localparam int MaxCoeffs   = 64;
  localparam int ResultLimit = 64;

  // Field widths.
  localparam int OpW    = 2;
  localparam int IdxW   = 6;
  localparam int ValW   = 24;
  localparam int CntW   = 7;
  localparam int PredW  = 32;
  localparam int StatW  = 2;
  localparam int CfgIdW = 2;
  localparam int ProdW  = 2 * ValW;
  localparam int FracW  = 12;
  localparam int ShW    = ProdW - FracW;
  // Up to 127 terms of ShW bits each.
  localparam int AccW   = ShW + CntW + 1;

  // Item operations.
  localparam logic [OpW-1:0] OpWrCoeff = 2'd0;
  localparam logic [OpW-1:0] OpWrMove  = 2'd1;
  localparam logic [OpW-1:0] OpRun     = 2'd2;

  // Result status codes.
  localparam logic [StatW-1:0] StatusOk       = 2'd0;
  localparam logic [StatW-1:0] StatusZeroCnt  = 2'd1;
  localparam logic [StatW-1:0] StatusPastOver = 2'd2;

  // Register indexes.
  localparam logic [CfgIdW-1:0] CfgCoeffCount = 2'd0;
  localparam logic [CfgIdW-1:0] CfgPastCount  = 2'd1;
  localparam logic [CfgIdW-1:0] CfgPredCount  = 2'd2;

  // Register reset values.
  localparam logic [CntW-1:0] CoeffCountRst = 7'd64;
  localparam logic [CntW-1:0] PastCountRst  = 7'd1;
  localparam logic [CntW-1:0] PredCountRst  = 7'd1;

endpackage

`default_nettype wire

// ----- rtl/step_response_prediction.sv -----
// Write items (coefficient or move) keep busy_o low.
// A run that fails its count checks gives its single result in the cycle after start.
// Otherwise each prediction step runs past_count products through the one shared
// multiply-accumulate unit, and the steps run one after another for pred_count results, at most 64.
// Results are strobed for one cycle by valid_o; the receiver cannot stall them.
// Reset clears the control state and sets the counts to 64, 1 and 1; the stores are not cleared.
`default_nettype none

module step_response_prediction
  import srp_pkg::*;
#(
  parameter int MAX_COEFFS = MaxCoeffs
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  output logic                    busy_o,
  input  wire  [OpW-1:0]          operation_i,
  input  wire  [IdxW-1:0]         index_i,
  input  wire  signed [ValW-1:0]  value_i,
  input  wire                     cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire  [CfgIdW-1:0]       cfg_index_i,
  input  wire  [CntW-1:0]         cfg_data_i,
  output logic                    valid_o,
  output logic [IdxW-1:0]         step_index_o,
  output logic signed [PredW-1:0] prediction_o,
  output logic [StatW-1:0]        status_o,
  output logic                    last_o
);

  localparam int AW = $clog2(MAX_COEFFS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state_q, state_d;

  logic [CntW-1:0] coeff_count_q, past_count_q, pred_count_q;
  logic [CntW-1:0] np_q, np_d, npred_q, npred_d, nm1_q, nm1_d;
  logic [CntW-1:0] j_q, j_d;
  logic [IdxW-1:0] p_q, p_d;

  logic rd_vld_q, rd_vld_d, prod_vld_q;
  logic signed [ValW-1:0]  coef_mem [MAX_COEFFS];
  logic signed [ValW-1:0]  move_mem [MAX_COEFFS];
  logic signed [ValW-1:0]  coef_rd_q, move_rd_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, acc_d;

  logic accept, wr_ok;
  logic [CntW-1:0] n_eff, npred_eff;
  logic [CntW:0]   ci_sum, ci_clamp;
  logic [CntW-1:0] mi;
  logic [AW-1:0]   coef_addr, move_addr;
  logic signed [ProdW-1:0] prod_sh;
  logic signed [PredW-1:0] acc_sat;

  logic                    out_vld_d;
  logic [IdxW-1:0]         out_step_d;
  logic signed [PredW-1:0] out_pred_d;
  logic [StatW-1:0]        out_stat_d;
  logic                    out_last_d;

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign wr_ok       = (32'(index_i) < MAX_COEFFS);

  assign n_eff     = (32'(coeff_count_q) > MAX_COEFFS) ? CntW'(MAX_COEFFS) : coeff_count_q;
  assign npred_eff = (32'(pred_count_q) > ResultLimit) ? CntW'(ResultLimit) : pred_count_q;

  // Coefficient index runs past the end of the model and is held at its last entry.
  assign ci_sum    = {2'b00, p_q} + {1'b0, j_q};
  assign ci_clamp  = (ci_sum > {1'b0, nm1_q}) ? {1'b0, nm1_q} : ci_sum;
  assign mi        = np_q - CntW'(1) - j_q;
  assign coef_addr = AW'(ci_clamp);
  assign move_addr = AW'(mi);

  assign prod_sh = prod_q >>> FracW;

  always_comb begin
    if (acc_q > AccW'(signed'(32'sh7fffffff))) begin
      acc_sat = 32'sh7fffffff;
    end else if (acc_q < AccW'(signed'(32'sh80000000))) begin
      acc_sat = 32'sh80000000;
    end else begin
      acc_sat = acc_q[PredW-1:0];
    end
  end

  // Config registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_count_q <= CoeffCountRst;
      past_count_q  <= PastCountRst;
      pred_count_q  <= PredCountRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgCoeffCount: coeff_count_q <= cfg_data_i;
        CfgPastCount:  past_count_q  <= cfg_data_i;
        CfgPredCount:  pred_count_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Coefficient and move stores with registered reads.
  always_ff @(posedge clk_i) begin
    if (accept && wr_ok && operation_i == OpWrCoeff) begin
      coef_mem[AW'(index_i)] <= value_i;
    end
    coef_rd_q <= coef_mem[coef_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && wr_ok && operation_i == OpWrMove) begin
      move_mem[AW'(index_i)] <= value_i;
    end
    move_rd_q <= move_mem[move_addr];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= coef_rd_q * move_rd_q;
  end

  always_comb begin
    state_d    = state_q;
    np_d       = np_q;
    npred_d    = npred_q;
    nm1_d      = nm1_q;
    j_d        = j_q;
    p_d        = p_q;
    rd_vld_d   = 1'b0;
    acc_d      = acc_q;
    out_vld_d  = 1'b0;
    out_step_d = step_index_o;
    out_pred_d = prediction_o;
    out_stat_d = status_o;
    out_last_d = last_o;

    if (prod_vld_q) begin
      acc_d = acc_q + {{(AccW-ShW){prod_sh[ShW-1]}}, prod_sh[ShW-1:0]};
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept && operation_i == OpRun) begin
          np_d    = past_count_q;
          npred_d = npred_eff;
          nm1_d   = n_eff - CntW'(1);
          j_d     = '0;
          p_d     = '0;
          acc_d   = '0;
          if (past_count_q == '0 || npred_eff == '0) begin
            out_vld_d  = 1'b1;
            out_step_d = '0;
            out_pred_d = '0;
            out_stat_d = StatusZeroCnt;
            out_last_d = 1'b1;
          end else if (past_count_q > n_eff) begin
            out_vld_d  = 1'b1;
            out_step_d = '0;
            out_pred_d = '0;
            out_stat_d = StatusPastOver;
            out_last_d = 1'b1;
          end else begin
            state_d = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        rd_vld_d = 1'b1;
        j_d      = j_q + CntW'(1);
        if (j_q == np_q - CntW'(1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last product has been added once both pipeline flags are clear.
        if (!rd_vld_q && !prod_vld_q) begin
          out_vld_d  = 1'b1;
          out_step_d = p_q;
          out_pred_d = acc_sat;
          out_stat_d = StatusOk;
          out_last_d = ({1'b0, p_q} == npred_q - CntW'(1));
          acc_d      = '0;
          j_d        = '0;
          p_d        = p_q + IdxW'(1);
          state_d    = out_last_d ? S_IDLE : S_ISSUE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      valid_o    <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= rd_vld_d;
      prod_vld_q <= rd_vld_q;
      valid_o    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    np_q         <= np_d;
    npred_q      <= npred_d;
    nm1_q        <= nm1_d;
    j_q          <= j_d;
    p_q          <= p_d;
    acc_q        <= acc_d;
    step_index_o <= out_step_d;
    prediction_o <= out_pred_d;
    status_o     <= out_stat_d;
    last_o       <= out_last_d;
  end

  // An error result always closes its run.
  a_err_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != StatusOk |-> last_o)
    else $error("error result without last");

  // The multiply-accumulate pipeline is empty whenever the block is idle.
  a_idle_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !rd_vld_q && !prod_vld_q)
    else $error("MAC pipeline busy while idle");

  // A run either starts working or answers at once.
  a_run_resp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && operation_i == OpRun |=> busy_o || valid_o)
    else $error("run item dropped");

  // The final good result carries the last step number.
  a_last_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o && status_o == StatusOk |-> {1'b0, step_index_o} == npred_q - CntW'(1))
    else $error("last result at wrong step");

  // Write items never raise busy.
  a_wr_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && operation_i != OpRun |=> !busy_o && !valid_o)
    else $error("write item caused activity");

endmodule

`default_nettype wire
